// ===== sv/fatsn_pkg.sv =====
package fatsn_pkg;

   localparam int NAME_LEN = 11;
   localparam int EXT_POS = 8;
   localparam int CSR_BITS = 12;
   localparam int POS_BITS = 4;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT = 8'h2e;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] DIR_VOL_MASK = 8'h18;
   localparam logic [CSR_BITS-1:0] MAX_ENTRIES_RESET = 12'd224;

   localparam logic [1:0] FUNC_BEGIN = 2'd0;
   localparam logic [1:0] FUNC_NAME_CHAR = 2'd1;
   localparam logic [1:0] FUNC_ENTRY = 2'd2;

   typedef enum logic [1:0] {
      STATUS_NONE = 2'd0,
      STATUS_FOUND = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  name_char;
      logic [63:0] entry_name_lo;
      logic [23:0] entry_name_hi;
      logic [7:0]  entry_type;
   } item_type;

endpackage

// ===== sv/fat_short_name_directory_match.sv =====
// FAT 8.3 short-name directory search.
// req channel: one item per transfer. req_func selects begin (clear the name
// buffer and search state), name character (req_name_char) or directory entry
// (req_entry_name_lo/hi, req_entry_type). Every item gives exactly one rsp
// transfer: rsp_status is none, found or not found, rsp_match_index is the
// entry index on found and zero otherwise.
// csr channel: writes max_entries, the number of entries searched before the
// search gives up; write it only while no item is in flight.
// An item is held in the input register; the search step writes its result into
// the output register once that is empty or being taken. Throughput is one item
// per cycle while rsp_ready stays high, set by the single register-to-register
// compare of all 11 name bytes.
// A stalled rsp side keeps its result; one more item waits in the input
// register, after which req_ready drops until the rsp transfer.
// Reset (synchronous) empties both registers, clears the name to spaces and
// sets max_entries to 224.
module fat_short_name_directory_match #(
   parameter int INDEX_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_func,
   input  logic [7:0]                     req_name_char,
   input  logic [63:0]                    req_entry_name_lo,
   input  logic [23:0]                    req_entry_name_hi,
   input  logic [7:0]                     req_entry_type,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [INDEX_BITS-1:0]          rsp_match_index,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [fatsn_pkg::CSR_BITS-1:0] csr_max_entries
);
   import fatsn_pkg::*;

   item_type              req_item_ff;
   logic                  req_full_ff;
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [INDEX_BITS-1:0] rsp_match_index_ff;
   logic [CSR_BITS-1:0]   max_entries_ff;

   logic                  advance;
   status_type            step_status;
   logic [INDEX_BITS-1:0] step_index;

   assign advance   = req_full_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_full_ff || advance;
   assign csr_ready = 1'b1;

   fatsn_search #(
      .INDEX_BITS (INDEX_BITS)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (req_item_ff),
      .max_entries (max_entries_ff),
      .status      (step_status),
      .match_index (step_index)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         max_entries_ff <= MAX_ENTRIES_RESET;
      end else begin
         if (req_valid && req_ready) begin
            req_full_ff <= 1'b1;
         end else if (advance) begin
            req_full_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            max_entries_ff <= csr_max_entries;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_item_ff.func          <= req_func;
         req_item_ff.name_char     <= req_name_char;
         req_item_ff.entry_name_lo <= req_entry_name_lo;
         req_item_ff.entry_name_hi <= req_entry_name_hi;
         req_item_ff.entry_type    <= req_entry_type;
      end
      if (advance) begin
         rsp_status_ff      <= step_status;
         rsp_match_index_ff <= step_index;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_index = rsp_match_index_ff;

   advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed item left no result");

   empty_input_takes_transfer: assert property (@(posedge clock) disable iff (reset)
      !req_full_ff |-> req_ready)
      else $error("input register empty but not ready");

   index_zero_unless_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_FOUND |-> rsp_match_index == '0)
      else $error("index given without a match");

   status_code_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_NONE || rsp_status == STATUS_FOUND ||
                    rsp_status == STATUS_NOT_FOUND)
      else $error("undefined status code");

endmodule

// ===== sv/fatsn_search.sv =====
module fatsn_search #(
   parameter int INDEX_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  fatsn_pkg::item_type            item,
   input  logic [fatsn_pkg::CSR_BITS-1:0] max_entries,
   output fatsn_pkg::status_type          status,
   output logic [INDEX_BITS-1:0]          match_index
);
   import fatsn_pkg::*;

   localparam int CMP_BITS = (INDEX_BITS > CSR_BITS) ? INDEX_BITS : CSR_BITS;

   logic [7:0]            short_name_ff [NAME_LEN];
   logic [7:0]            short_name_in [NAME_LEN];
   logic [POS_BITS-1:0]   name_position_ff, name_position_in;
   logic                  name_overflow_ff, name_overflow_in;
   logic [INDEX_BITS-1:0] entry_counter_ff, entry_counter_in;
   logic                  search_done_ff, search_done_in;

   logic [87:0]           entry_bytes;
   logic                  name_equal;
   logic                  give_up;
   logic [7:0]            upper_char;
   logic [CMP_BITS-1:0]   counter_ext, limit_ext;

   assign entry_bytes = {item.entry_name_hi, item.entry_name_lo};
   assign counter_ext = CMP_BITS'(entry_counter_ff);
   assign limit_ext   = CMP_BITS'(max_entries);

   always_comb begin
      name_equal = 1'b1;
      for (int k = 0; k < NAME_LEN; k++) begin
         if (entry_bytes[8*k +: 8] != short_name_ff[k]) begin
            name_equal = 1'b0;
         end
      end
   end

   // limit is checked ahead of the end-of-directory marker
   assign give_up = name_overflow_ff || (counter_ext >= limit_ext) ||
                    (&entry_counter_ff) || (item.entry_name_lo[7:0] == CHAR_NUL);

   always_comb begin
      if (item.name_char inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         upper_char = item.name_char - CHAR_SPACE;
      end else begin
         upper_char = item.name_char;
      end
   end

   always_comb begin
      short_name_in    = short_name_ff;
      name_position_in = name_position_ff;
      name_overflow_in = name_overflow_ff;
      entry_counter_in = entry_counter_ff;
      search_done_in   = search_done_ff;
      status           = STATUS_NONE;
      match_index      = '0;
      case (item.func)
         FUNC_BEGIN: begin
            for (int k = 0; k < NAME_LEN; k++) begin
               short_name_in[k] = CHAR_SPACE;
            end
            name_position_in = '0;
            name_overflow_in = 1'b0;
            entry_counter_in = '0;
            search_done_in   = 1'b0;
         end
         FUNC_NAME_CHAR: begin
            if (item.name_char == CHAR_NUL) begin
               // nul bytes are dropped
            end else if (name_position_ff >= POS_BITS'(NAME_LEN)) begin
               name_overflow_in = 1'b1;
            end else if (item.name_char == CHAR_DOT &&
                         name_position_ff <= POS_BITS'(EXT_POS)) begin
               name_position_in = POS_BITS'(EXT_POS);
            end else begin
               for (int k = 0; k < NAME_LEN; k++) begin
                  if (name_position_ff == POS_BITS'(k)) begin
                     short_name_in[k] = upper_char;
                  end
               end
               name_position_in = name_position_ff + 1'b1;
            end
         end
         FUNC_ENTRY: begin
            if (!search_done_ff) begin
               if (give_up) begin
                  search_done_in = 1'b1;
                  status         = STATUS_NOT_FOUND;
               end else if ((item.entry_type & DIR_VOL_MASK) == 8'h00 && name_equal) begin
                  search_done_in = 1'b1;
                  status         = STATUS_FOUND;
                  match_index    = entry_counter_ff;
               end else begin
                  entry_counter_in = entry_counter_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NAME_LEN; k++) begin
            short_name_ff[k] <= CHAR_SPACE;
         end
         name_position_ff <= '0;
         name_overflow_ff <= 1'b0;
         entry_counter_ff <= '0;
         search_done_ff   <= 1'b0;
      end else if (step) begin
         short_name_ff    <= short_name_in;
         name_position_ff <= name_position_in;
         name_overflow_ff <= name_overflow_in;
         entry_counter_ff <= entry_counter_in;
         search_done_ff   <= search_done_in;
      end
   end

   position_in_range: assert property (@(posedge clock) disable iff (reset)
      name_position_ff <= POS_BITS'(NAME_LEN))
      else $error("name position beyond buffer");

   done_holds_without_begin: assert property (@(posedge clock) disable iff (reset)
      search_done_ff && !(step && item.func == FUNC_BEGIN) |=> search_done_ff)
      else $error("search decision dropped without begin");

   decision_only_once: assert property (@(posedge clock) disable iff (reset)
      search_done_ff |-> status == STATUS_NONE)
      else $error("second decision after search ended");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fatsn_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1150;
   localparam logic [11:0] INDEX_ALL_ONES = 12'hFFF;
   localparam logic [11:0] WIDE_LIMIT = 12'd60;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      status_type  status;
      logic [11:0] index;
   } search_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_func;
   logic [7:0]  req_name_char;
   logic [63:0] req_entry_name_lo;
   logic [23:0] req_entry_name_hi;
   logic [7:0]  req_entry_type;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_match_index;
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_BITS-1:0] csr_max_entries;

   // predicted search state
   logic [7:0]  name_buf [NAME_LEN];
   int          name_pos;
   bit          name_too_long;
   logic [11:0] entries_seen;
   bit          search_over;
   logic [11:0] max_entries_cfg = MAX_ENTRIES_RESET;

   search_result_type due_results[$];
   int  errors = 0;
   int  items_sent = 0;
   int  idle_cycles = 0;
   bit  no_gaps = 1'b0;

   fat_short_name_directory_match u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_name_char     (req_name_char),
      .req_entry_name_lo (req_entry_name_lo),
      .req_entry_name_hi (req_entry_name_hi),
      .req_entry_type    (req_entry_type),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_match_index   (rsp_match_index),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_entries   (csr_max_entries)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= no_gaps || ($urandom_range(99) >= 6);
   end

   function automatic void clear_name_state();
      for (int k = 0; k < NAME_LEN; k++) name_buf[k] = CHAR_SPACE;
      name_pos = 0;
      name_too_long = 1'b0;
      entries_seen = '0;
      search_over = 1'b0;
   endfunction

   // buffer laid out like {entry_name_hi, entry_name_lo}
   function automatic logic [87:0] packed_name();
      logic [87:0] p;
      for (int k = 0; k < NAME_LEN; k++) p[8*k +: 8] = name_buf[k];
      return p;
   endfunction

   task automatic predict_search(input item_type it);
      search_result_type r;
      logic [7:0]        c;
      r.status = STATUS_NONE;
      r.index = '0;
      case (it.func)
         FUNC_BEGIN: clear_name_state();
         FUNC_NAME_CHAR: begin
            c = it.name_char;
            if (c != CHAR_NUL) begin
               if (name_pos >= NAME_LEN) begin
                  name_too_long = 1'b1;
               end else if (c == CHAR_DOT && name_pos <= EXT_POS) begin
                  name_pos = EXT_POS;
               end else begin
                  if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) c = c - CHAR_SPACE;
                  name_buf[name_pos] = c;
                  name_pos++;
               end
            end
         end
         FUNC_ENTRY: begin
            if (!search_over) begin
               // limit is tested ahead of the empty-slot marker
               if (name_too_long || entries_seen >= max_entries_cfg ||
                   entries_seen == INDEX_ALL_ONES || it.entry_name_lo[7:0] == CHAR_NUL) begin
                  search_over = 1'b1;
                  r.status = STATUS_NOT_FOUND;
               end else if ((it.entry_type & DIR_VOL_MASK) == '0 &&
                            {it.entry_name_hi, it.entry_name_lo} == packed_name()) begin
                  search_over = 1'b1;
                  r.status = STATUS_FOUND;
                  r.index = entries_seen;
               end else begin
                  entries_seen = entries_seen + 12'd1;
               end
            end
         end
         default: ;
      endcase
      due_results.push_back(r);
   endtask

   always @(posedge clock) begin
      search_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            $display("%0t: response with nothing due: status %0d index %0d",
                     $time, rsp_status, rsp_match_index);
            errors++;
         end else begin
            want = due_results.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
               errors++;
            end
            if (rsp_match_index !== want.index) begin
               $display("%0t: match_index expected %0d actual %0d",
                        $time, want.index, rsp_match_index);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic item_type noise_item();
      item_type it;
      it.func = 2'($urandom_range(3));
      it.name_char = 8'($urandom);
      it.entry_name_lo = {$urandom, $urandom};
      it.entry_name_hi = 24'($urandom);
      it.entry_type = 8'($urandom);
      return it;
   endfunction

   function automatic logic [7:0] rand_name_char();
      case ($urandom_range(9))
         0, 1, 2: return 8'($urandom_range(8'h41, 8'h5a));
         3, 4:    return 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
         5:       return 8'($urandom_range(8'h30, 8'h39));
         6:       return CHAR_DOT;
         7:       return ($urandom_range(3) == 0) ? CHAR_NUL : 8'h5f;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_item(input item_type it);
      @(negedge clock);
      if (!no_gaps) begin
         while ($urandom_range(99) < 6) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_func <= it.func;
      req_name_char <= it.name_char;
      req_entry_name_lo <= it.entry_name_lo;
      req_entry_name_hi <= it.entry_name_hi;
      req_entry_type <= it.entry_type;
      do @(posedge clock); while (!req_ready);
      predict_search(it);
      items_sent++;
   endtask

   task automatic send_begin();
      item_type it;
      it = noise_item();
      it.func = FUNC_BEGIN;
      send_item(it);
   endtask

   task automatic send_char(input logic [7:0] c);
      item_type it;
      it = noise_item();
      it.func = FUNC_NAME_CHAR;
      it.name_char = c;
      send_item(it);
   endtask

   task automatic send_entry(input logic [87:0] name, input logic [7:0] attr);
      item_type it;
      it = noise_item();
      it.func = FUNC_ENTRY;
      {it.entry_name_hi, it.entry_name_lo} = name;
      it.entry_type = attr;
      send_item(it);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic write_max_entries(input logic [CSR_BITS-1:0] value);
      release_req();
      while (due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_max_entries <= value;
      do @(posedge clock); while (!csr_ready);
      max_entries_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_name_and_match();
      string s;
      s = "read.me";
      send_begin();
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
      // directory and volume entries with the right name must not match
      send_entry(packed_name(), 8'h10);
      send_entry(packed_name(), 8'h08);
      send_entry(packed_name(), 8'he7);
      send_entry(packed_name(), 8'h00);
   endtask

   task automatic test_special_cases();
      logic [87:0] other;
      send_begin();
      send_char(CHAR_NUL);
      for (int i = 0; i < NAME_LEN; i++) send_char(8'h41 + 8'(i));
      send_char(8'h62);
      send_entry(packed_name(), 8'h00);
      send_item('{func: FUNC_UNUSED, name_char: 8'hff, entry_name_lo: '1,
                 entry_name_hi: '1, entry_type: 8'hff});
      send_begin();
      send_entry({80'h0, CHAR_NUL}, 8'h00);
      // name grows after an entry was already compared
      send_begin();
      send_char(CHAR_LOWER_A);
      other = packed_name();
      other[7:0] = 8'h5a;
      send_entry(other, 8'h00);
      send_char(CHAR_DOT);
      send_char(8'h63);
      send_entry(packed_name(), 8'h01);
   endtask

   task automatic test_entry_limit_extremes();
      logic [87:0] other;
      write_max_entries('0);
      send_begin();
      send_entry(88'({$urandom, $urandom, $urandom}) | 88'h41, 8'h00);
      // search stops at a limit well above the session lengths
      write_max_entries(WIDE_LIMIT);
      send_begin();
      send_char(8'h51);
      for (int i = 0; i <= int'(WIDE_LIMIT); i++) begin
         other = 88'({$urandom, $urandom, $urandom});
         other[7:0] = 8'h5a;
         send_entry(other, 8'($urandom));
      end
      write_max_entries(MAX_ENTRIES_RESET);
   endtask

   task automatic run_search_session();
      item_type it;
      int       len;
      int       n_entries;
      int       roll;
      send_begin();
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 14) : $urandom_range(1, 11);
      for (int i = 0; i < len; i++) send_char(rand_name_char());
      n_entries = $urandom_range(1, 12);
      for (int i = 0; i < n_entries; i++) begin
         it = noise_item();
         it.func = FUNC_ENTRY;
         roll = $urandom_range(99);
         if (roll < 40) begin
            if (it.entry_name_lo[7:0] == CHAR_NUL) it.entry_name_lo[7:0] = 8'h5a;
         end else if (roll < 60) begin
            {it.entry_name_hi, it.entry_name_lo} =
               packed_name() ^ (88'd1 << $urandom_range(87));
         end else if (roll < 78) begin
            {it.entry_name_hi, it.entry_name_lo} = packed_name();
            if ($urandom_range(3) != 0) it.entry_type = it.entry_type & ~DIR_VOL_MASK;
         end else if (roll < 83) begin
            it.entry_name_lo[7:0] = CHAR_NUL;
         end else if (roll < 90) begin
            it.func = FUNC_NAME_CHAR;
            it.name_char = rand_name_char();
         end else if (roll < 95) begin
            it.func = FUNC_UNUSED;
         end else begin
            it.func = FUNC_BEGIN;
         end
         send_item(it);
      end
   endtask

   task automatic test_random_searches();
      logic [CSR_BITS-1:0] settings [8];
      int phase_start;
      int budget;
      settings = '{MAX_ENTRIES_RESET, 12'd1, 12'd3, 12'hfff,
                   12'($urandom_range(4, 4094)), 12'd2, 12'd0, 12'hfff};
      for (int p = 0; p < 8; p++) begin
         if (settings[p] != max_entries_cfg) write_max_entries(settings[p]);
         no_gaps = (p == 3);
         budget = (settings[p] == '0) ? 20 : RANDOM_ITEMS / 8;
         phase_start = items_sent;
         while (items_sent - phase_start < budget) run_search_session();
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_BEGIN;
      req_name_char = '0;
      req_entry_name_lo = '0;
      req_entry_name_hi = '0;
      req_entry_type = '0;
      csr_valid = 1'b0;
      csr_max_entries = MAX_ENTRIES_RESET;
      clear_name_state();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_name_and_match();
      test_special_cases();
      test_entry_limit_extremes();
      test_random_searches();

      release_req();
      while (due_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== fat_short_name_directory_match.f =====
sv/fatsn_pkg.sv
sv/fatsn_search.sv
sv/fat_short_name_directory_match.sv
tb/tb_top.sv
